### src/awbs_pkg.sv
// awbs_pkg: shared types and constants for the alpha weighted bilinear sampler
// used by awbs_div and alpha_weighted_bilinear_sample_unit, depends on nothing
`default_nettype none

package awbs_pkg;

  localparam int PIX_W     = 64;
  localparam int FRAC_IN_W = 16;
  localparam int CH_W      = 16;
  localparam int CH_W_8    = 8;
  localparam int NUM_PIX   = 4;
  localparam int NUM_COL   = 3;
  localparam int QUO_W     = 16;
  localparam int CMAX_8    = 255;

  typedef enum logic {
    MODE_8BIT  = 1'b0,
    MODE_16BIT = 1'b1
  } mode_t;

  typedef logic [CH_W-1:0] chan_t;

endpackage

`default_nettype wire

### src/awbs_div.sv
// awbs_div: pipelined restoring divider, one quotient bit per stage, three lanes
// sharing one divisor, with an overflow check stage in front; uses awbs_pkg
`default_nettype none

module awbs_div #(
  parameter int FRAC_BITS = 16,
  parameter int TAG_W     = 17
) (
  input  logic                         clk,
  input  logic [awbs_pkg::QUO_W:0]     en,
  input  logic [2*FRAC_BITS+32:0]      rem_in [awbs_pkg::NUM_COL],
  input  logic [2*FRAC_BITS+16:0]      div_in,
  input  logic [TAG_W-1:0]             tag_in,
  output logic [awbs_pkg::QUO_W-1:0]   quo [awbs_pkg::NUM_COL],
  output logic [awbs_pkg::NUM_COL-1:0] sat,
  output logic [TAG_W-1:0]             tag
);

  localparam int QW   = awbs_pkg::QUO_W;
  localparam int NCOL = awbs_pkg::NUM_COL;
  localparam int RW   = 2 * FRAC_BITS + 33;
  localparam int DW   = 2 * FRAC_BITS + 17;

  logic [RW-1:0]   rem_r [QW][NCOL];
  logic [DW-1:0]   div_r [QW];
  logic [QW-1:0]   quo_r [QW+1][NCOL];
  logic [NCOL-1:0] sat_r [QW+1];
  logic [TAG_W-1:0] tag_r [QW+1];

  // quotient at or above 2^QW saturates
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < NCOL; c++) begin
        rem_r[0][c] <= rem_in[c];
        quo_r[0][c] <= '0;
        sat_r[0][c] <= (rem_in[c] >= {div_in, {QW{1'b0}}});
      end
      div_r[0] <= div_in;
      tag_r[0] <= tag_in;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int B = QW - j;
    logic [RW-1:0]   shd;
    logic [RW-1:0]   rem_next [NCOL];
    logic [QW-1:0]   quo_next [NCOL];
    logic [NCOL-1:0] ge;

    assign shd = {{QW{1'b0}}, div_r[j-1]} << B;

    always_comb begin
      for (int c = 0; c < NCOL; c++) begin
        ge[c]       = (rem_r[j-1][c] >= shd);
        rem_next[c] = ge[c] ? (rem_r[j-1][c] - shd) : rem_r[j-1][c];
        quo_next[c] = quo_r[j-1][c];
        quo_next[c][B] = ge[c];
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        for (int c = 0; c < NCOL; c++) begin
          quo_r[j][c] <= quo_next[c];
        end
        sat_r[j] <= sat_r[j-1];
        tag_r[j] <= tag_r[j-1];
      end
    end

    if (j < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[j]) begin
          for (int c = 0; c < NCOL; c++) begin
            rem_r[j][c] <= rem_next[c];
          end
          div_r[j] <= div_r[j-1];
        end
      end
    end
  end

  assign quo = quo_r[QW];
  assign sat = sat_r[QW];
  assign tag = tag_r[QW];

endmodule

`default_nettype wire

### src/alpha_weighted_bilinear_sample_unit.sv
// alpha weighted bilinear sampler, top level: weight, product and sum stages,
// then awbs_div for the three colour channels, then the output register
// one result word per cycle while result_ready is high; result_ready low stalls the pipeline
// pipeline depth set by the 16-bit quotient of the colour divide, one bit per stage
// reset empties the pipeline and sets 8-bit channel mode
`default_nettype none

module alpha_weighted_bilinear_sample_unit #(
  parameter int COLOR_MAX_16 = 32768,
  parameter int FRAC_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic [63:0] pixel_top_left,
  input  logic [63:0] pixel_top_right,
  input  logic [63:0] pixel_bottom_left,
  input  logic [63:0] pixel_bottom_right,
  input  logic [15:0] frac_x,
  input  logic [15:0] frac_y,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [63:0] result_pixel
);

  localparam int F       = FRAC_BITS;
  localparam int FIW     = awbs_pkg::FRAC_IN_W;
  localparam int NPIX    = awbs_pkg::NUM_PIX;
  localparam int NCOL    = awbs_pkg::NUM_COL;
  localparam int CW      = awbs_pkg::CH_W;
  localparam int CW8     = awbs_pkg::CH_W_8;
  localparam int QW      = awbs_pkg::QUO_W;
  localparam int WW      = 2 * F + 1;
  localparam int PW      = 2 * F + 16;
  localparam int NW      = 2 * F + 32;
  localparam int RW      = 2 * F + 33;
  localparam int DW      = 2 * F + 17;
  localparam int TAG_W   = CW + 1;
  localparam int DIV_STG = QW + 1;
  localparam int FRONT   = 6;
  localparam int NSTG    = FRONT + DIV_STG + 1;

  localparam logic [F:0]    ONE    = (F+1)'(1) << F;
  localparam logic [PW-1:0] HALF   = PW'(1) << (2 * F - 1);
  localparam logic [CW-1:0] CMAX16 = CW'(COLOR_MAX_16);
  localparam logic [CW-1:0] CMAX8  = CW'(awbs_pkg::CMAX_8);

  awbs_pkg::mode_t mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= awbs_pkg::MODE_8BIT;
    end else if (cfg_wr_en) begin
      mode <= awbs_pkg::mode_t'(cfg_wr_data);
    end
  end

  // stall chain: a stage moves when it is empty or the next one moves
  logic [NSTG-1:0] vld;
  logic [NSTG:0]   en;

  assign en[NSTG] = result_ready;
  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= sample_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign sample_ready = en[0];
  assign result_valid = vld[NSTG-1];

  // stage 1: unpack channels
  logic [63:0]           pix_in [NPIX];
  awbs_pkg::chan_t       a_in   [NPIX];
  awbs_pkg::chan_t       c_in   [NPIX][NCOL];
  logic [F+FIW-1:0]      fx_ext;
  logic [F+FIW-1:0]      fy_ext;

  assign pix_in[0] = pixel_top_left;
  assign pix_in[1] = pixel_top_right;
  assign pix_in[2] = pixel_bottom_left;
  assign pix_in[3] = pixel_bottom_right;
  assign fx_ext    = {{F{1'b0}}, frac_x};
  assign fy_ext    = {{F{1'b0}}, frac_y};

  always_comb begin
    for (int i = 0; i < NPIX; i++) begin
      if (mode == awbs_pkg::MODE_16BIT) begin
        a_in[i] = pix_in[i][NCOL*CW +: CW];
      end else begin
        a_in[i] = {{(CW-CW8){1'b0}}, pix_in[i][NCOL*CW8 +: CW8]};
      end
      for (int c = 0; c < NCOL; c++) begin
        if (mode == awbs_pkg::MODE_16BIT) begin
          c_in[i][c] = pix_in[i][c*CW +: CW];
        end else begin
          c_in[i][c] = {{(CW-CW8){1'b0}}, pix_in[i][c*CW8 +: CW8]};
        end
      end
    end
  end

  logic [F-1:0]          s1_fx;
  logic [F-1:0]          s1_fy;
  awbs_pkg::chan_t       s1_a [NPIX];
  awbs_pkg::chan_t       s1_c [NPIX][NCOL];
  awbs_pkg::mode_t       s1_mode;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_fx   <= fx_ext[F-1:0];
      s1_fy   <= fy_ext[F-1:0];
      s1_a    <= a_in;
      s1_c    <= c_in;
      s1_mode <= mode;
    end
  end

  // stage 2: weights and colour times alpha
  logic [F:0]            omx;
  logic [F:0]            omy;
  logic [F:0]            fxe;
  logic [F:0]            fye;
  logic [2*F+1:0]        wprod [NPIX];
  logic [2*CW-1:0]       ca    [NPIX][NCOL];

  assign fxe = {1'b0, s1_fx};
  assign fye = {1'b0, s1_fy};
  assign omx = ONE - fxe;
  assign omy = ONE - fye;

  always_comb begin
    wprod[0] = omx * omy;
    wprod[1] = fxe * omy;
    wprod[2] = omx * fye;
    wprod[3] = fxe * fye;
    for (int i = 0; i < NPIX; i++) begin
      for (int c = 0; c < NCOL; c++) begin
        ca[i][c] = s1_c[i][c] * s1_a[i];
      end
    end
  end

  logic [WW-1:0]         s2_w  [NPIX];
  awbs_pkg::chan_t       s2_a  [NPIX];
  logic [2*CW-1:0]       s2_ca [NPIX][NCOL];
  awbs_pkg::mode_t       s2_mode;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NPIX; i++) begin
        s2_w[i] <= wprod[i][WW-1:0];
      end
      s2_a    <= s1_a;
      s2_ca   <= ca;
      s2_mode <= s1_mode;
    end
  end

  // stage 3: weight times alpha, weight times halves of colour alpha
  logic [WW+CW-1:0]      wa_p [NPIX];
  logic [WW+CW-1:0]      lo_p [NPIX][NCOL];
  logic [WW+CW-1:0]      hi_p [NPIX][NCOL];

  always_comb begin
    for (int i = 0; i < NPIX; i++) begin
      wa_p[i] = s2_w[i] * s2_a[i];
      for (int c = 0; c < NCOL; c++) begin
        lo_p[i][c] = s2_w[i] * s2_ca[i][c][CW-1:0];
        hi_p[i][c] = s2_w[i] * s2_ca[i][c][2*CW-1:CW];
      end
    end
  end

  logic [PW-1:0]         s3_wa  [NPIX];
  logic [PW-1:0]         s3_plo [NPIX][NCOL];
  logic [PW-1:0]         s3_phi [NPIX][NCOL];
  awbs_pkg::mode_t       s3_mode;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < NPIX; i++) begin
        s3_wa[i] <= wa_p[i][PW-1:0];
        for (int c = 0; c < NCOL; c++) begin
          s3_plo[i][c] <= lo_p[i][c][PW-1:0];
          s3_phi[i][c] <= hi_p[i][c][PW-1:0];
        end
      end
      s3_mode <= s2_mode;
    end
  end

  // stage 4: join halves, pairwise alpha sums
  logic [NW-1:0]         s4_pn [NPIX][NCOL];
  logic [PW-1:0]         s4_as01;
  logic [PW-1:0]         s4_as23;
  awbs_pkg::mode_t       s4_mode;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < NPIX; i++) begin
        for (int c = 0; c < NCOL; c++) begin
          s4_pn[i][c] <= {s3_phi[i][c], {CW{1'b0}}} + {{CW{1'b0}}, s3_plo[i][c]};
        end
      end
      s4_as01 <= s3_wa[0] + s3_wa[1];
      s4_as23 <= s3_wa[2] + s3_wa[3];
      s4_mode <= s3_mode;
    end
  end

  // stage 5: weighted sums
  logic [NW-1:0]         s5_num [NCOL];
  logic [PW-1:0]         s5_asum;
  awbs_pkg::mode_t       s5_mode;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < NCOL; c++) begin
        s5_num[c] <= s4_pn[0][c] + s4_pn[1][c] + s4_pn[2][c] + s4_pn[3][c];
      end
      s5_asum <= s4_as01 + s4_as23;
      s5_mode <= s4_mode;
    end
  end

  // stage 6: dividend 2*num + asum, divisor 2*asum, rounded alpha
  logic [PW-1:0]         arnd_sum;
  logic [RW-1:0]         s6_rem [NCOL];
  logic [DW-1:0]         s6_div;
  awbs_pkg::chan_t       s6_arnd;
  awbs_pkg::mode_t       s6_mode;

  assign arnd_sum = s5_asum + HALF;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < NCOL; c++) begin
        s6_rem[c] <= {s5_num[c], 1'b0} + {{(RW-PW){1'b0}}, s5_asum};
      end
      s6_div  <= {s5_asum, 1'b0};
      s6_arnd <= arnd_sum[PW-1:2*F];
      s6_mode <= s5_mode;
    end
  end

  logic [QW-1:0]         dq   [NCOL];
  logic [NCOL-1:0]       dsat;
  logic [TAG_W-1:0]      dtag;

  awbs_div #(
    .FRAC_BITS (FRAC_BITS),
    .TAG_W     (TAG_W)
  ) u_div (
    .clk    (clk),
    .en     (en[FRONT +: DIV_STG]),
    .rem_in (s6_rem),
    .div_in (s6_div),
    .tag_in ({s6_mode, s6_arnd}),
    .quo    (dq),
    .sat    (dsat),
    .tag    (dtag)
  );

  // output stage: clamp, pack, transparent when alpha rounds to zero
  awbs_pkg::chan_t       o_arnd;
  awbs_pkg::mode_t       o_mode;
  awbs_pkg::chan_t       cmax;
  awbs_pkg::chan_t       qc [NCOL];
  logic [63:0]           res_next;

  assign o_arnd = dtag[CW-1:0];
  assign o_mode = awbs_pkg::mode_t'(dtag[CW]);
  assign cmax   = (o_mode == awbs_pkg::MODE_16BIT) ? CMAX16 : CMAX8;

  always_comb begin
    for (int c = 0; c < NCOL; c++) begin
      if (dsat[c] || (dq[c] > cmax)) begin
        qc[c] = cmax;
      end else begin
        qc[c] = dq[c];
      end
    end
    if (o_arnd == '0) begin
      res_next = '0;
    end else if (o_mode == awbs_pkg::MODE_16BIT) begin
      res_next = {o_arnd, qc[2], qc[1], qc[0]};
    end else begin
      res_next = {32'b0, o_arnd[CW8-1:0], qc[2][CW8-1:0], qc[1][CW8-1:0], qc[0][CW8-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[NSTG-1]) begin
      result_pixel <= res_next;
    end
  end

endmodule

`default_nettype wire

### dv/tb_alpha_weighted_bilinear_sample_unit.sv
// testbench for alpha_weighted_bilinear_sample_unit: random and directed samples in both
// channel modes, a scoreboard class that predicts each result word and checks it in order
// depends on awbs_pkg and the unit itself
`default_nettype none

module tb_alpha_weighted_bilinear_sample_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS    = 16;
  localparam int COLOR_MAX_16 = 32768;
  localparam int LATENCY      = 24;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_AFTER   = 600;
  localparam int PHASE_ITEMS  = 300;
  localparam int NUM_PHASES   = 6;

  typedef enum int {
    PK_RANDOM,
    PK_CLEAR,
    PK_OPAQUE,
    PK_FAINT,
    PK_ZERO,
    PK_ONES,
    PK_EDGES
  } pixel_kind_t;

  typedef enum int {
    RX_ALWAYS,
    RX_HALF,
    RX_SPARSE,
    RX_MOSTLY,
    RX_TOGGLE
  } stall_style_t;

  class sample_scoreboard;
    awbs_pkg::mode_t mode;
    bit [63:0]       expected_pixels[$];
    int              errors;

    function new();
      mode   = awbs_pkg::MODE_8BIT;
      errors = 0;
    endfunction

    function void set_mode(awbs_pkg::mode_t m);
      mode = m;
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    function bit [63:0] interpolate(bit [3:0][63:0] px, bit [15:0] fx_in, bit [15:0] fy_in);
      bit [127:0] one_v, fx, fy, asum, arnd, num, q, c, cmask, cmax;
      bit [127:0] w[4];
      bit [127:0] alpha[4];
      bit [63:0]  res;
      int         cw, i, ch;
      one_v = 128'd1 << FRAC_BITS;
      fx    = {112'd0, fx_in} & (one_v - 128'd1);
      fy    = {112'd0, fy_in} & (one_v - 128'd1);
      w[0]  = (one_v - fx) * (one_v - fy);
      w[1]  = fx * (one_v - fy);
      w[2]  = (one_v - fx) * fy;
      w[3]  = fx * fy;
      cw    = (mode == awbs_pkg::MODE_16BIT) ? awbs_pkg::CH_W : awbs_pkg::CH_W_8;
      cmask = (128'd1 << cw) - 128'd1;
      cmax  = (mode == awbs_pkg::MODE_16BIT) ? 128'(COLOR_MAX_16) : 128'(awbs_pkg::CMAX_8);
      asum  = '0;
      for (i = 0; i < awbs_pkg::NUM_PIX; i++) begin
        alpha[i] = ({64'd0, px[i]} >> (3 * cw)) & cmask;
        asum     = asum + w[i] * alpha[i];
      end
      arnd = (asum + (128'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
      if (arnd == '0) return '0;
      res = arnd[63:0] << (3 * cw);
      for (ch = 0; ch < awbs_pkg::NUM_COL; ch++) begin
        num = '0;
        for (i = 0; i < awbs_pkg::NUM_PIX; i++) begin
          c   = ({64'd0, px[i]} >> (ch * cw)) & cmask;
          num = num + w[i] * c * alpha[i];
        end
        num = (num << 1) + asum;
        if (num >= asum * 128'd2 * (cmax + 128'd1)) begin
          q = cmax;
        end else begin
          q = num / (asum << 1);
          if (q > cmax) q = cmax;
        end
        res = res | ((q[63:0] & cmask[63:0]) << (ch * cw));
      end
      return res;
    endfunction

    function void note_sample(bit [63:0] tl, bit [63:0] tr, bit [63:0] bl, bit [63:0] br,
                              bit [15:0] fx, bit [15:0] fy);
      expected_pixels.push_back(interpolate({br, bl, tr, tl}, fx, fy));
    endfunction

    function void check_result(bit [63:0] got);
      bit [63:0] want;
      if (expected_pixels.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result word %h with no sample pending", got);
      end else begin
        want = expected_pixels.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("result_pixel mismatch: expected %h actual %h", want, got);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        sample_valid;
  logic        sample_ready;
  logic [63:0] pixel_top_left;
  logic [63:0] pixel_top_right;
  logic [63:0] pixel_bottom_left;
  logic [63:0] pixel_bottom_right;
  logic [15:0] frac_x;
  logic [15:0] frac_y;
  logic        result_valid;
  logic        result_ready;
  logic [63:0] result_pixel;

  sample_scoreboard sb;
  awbs_pkg::mode_t  cur_mode;
  int               samples_taken;
  int               quiet_cycles;
  int               burst_left;
  bit               hold_done;

  alpha_weighted_bilinear_sample_unit #(
    .COLOR_MAX_16(COLOR_MAX_16),
    .FRAC_BITS   (FRAC_BITS)
  ) DUT (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .sample_valid      (sample_valid),
    .sample_ready      (sample_ready),
    .pixel_top_left    (pixel_top_left),
    .pixel_top_right   (pixel_top_right),
    .pixel_bottom_left (pixel_bottom_left),
    .pixel_bottom_right(pixel_bottom_right),
    .frac_x            (frac_x),
    .frac_y            (frac_y),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .result_pixel      (result_pixel)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (sample_valid && sample_ready) begin
        sb.note_sample(pixel_top_left, pixel_top_right, pixel_bottom_left,
                       pixel_bottom_right, frac_x, frac_y);
        samples_taken++;
      end
      if (result_valid && result_ready) sb.check_result(result_pixel);
      if ((sample_valid && sample_ready) || (result_valid && result_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver stall pattern, with one long hold-off once the stream is going
  initial begin
    int           run_left;
    stall_style_t style;
    result_ready = 1'b0;
    run_left     = 0;
    style        = RX_ALWAYS;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && samples_taken >= HOLD_AFTER) begin
        result_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (run_left == 0) begin
        style    = stall_style_t'($urandom_range(0, 4));
        run_left = $urandom_range(1, 60);
      end
      run_left--;
      case (style)
        RX_ALWAYS: result_ready = 1'b1;
        RX_HALF:   result_ready = 1'($urandom_range(0, 1));
        RX_SPARSE: result_ready = ($urandom_range(0, 3) == 0);
        RX_MOSTLY: result_ready = ($urandom_range(0, 7) != 0);
        default:   result_ready = ~result_ready;
      endcase
      @(negedge clk);
    end
  end

  function automatic int chan_width();
    return (cur_mode == awbs_pkg::MODE_16BIT) ? awbs_pkg::CH_W : awbs_pkg::CH_W_8;
  endfunction

  function automatic logic [63:0] make_pixel(pixel_kind_t kind);
    logic [63:0] px, amask, fld;
    int          cw, ch;
    bit          wide;
    cw    = chan_width();
    wide  = (cur_mode == awbs_pkg::MODE_16BIT);
    amask = ((64'd1 << cw) - 64'd1) << (3 * cw);
    px    = {$urandom, $urandom};
    case (kind)
      PK_CLEAR:  px = px & ~amask;
      PK_OPAQUE: px = px | amask;
      PK_FAINT:  px = (px & ~amask) | (64'($urandom_range(1, 3)) << (3 * cw));
      PK_ZERO:   px = '0;
      PK_ONES:   px = '1;
      PK_EDGES: begin
        for (ch = 0; ch < awbs_pkg::NUM_PIX; ch++) begin
          case ($urandom_range(0, 4))
            0:       fld = '0;
            1:       fld = (64'd1 << cw) - 64'd1;
            2:       fld = wide ? 64'(COLOR_MAX_16) : 64'(awbs_pkg::CMAX_8);
            3:       fld = wide ? 64'(COLOR_MAX_16 + 1) : 64'd1;
            default: fld = wide ? 64'(COLOR_MAX_16 - 1) : 64'(awbs_pkg::CMAX_8 - 1);
          endcase
          px = (px & ~(((64'd1 << cw) - 64'd1) << (ch * cw))) | (fld << (ch * cw));
        end
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic logic [15:0] make_frac();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'($urandom_range(0, 3));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic offer_sample(input logic [63:0] tl, input logic [63:0] tr,
                              input logic [63:0] bl, input logic [63:0] br,
                              input logic [15:0] fx, input logic [15:0] fy);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        sample_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    sample_valid       = 1'b1;
    pixel_top_left     = tl;
    pixel_top_right    = tr;
    pixel_bottom_left  = bl;
    pixel_bottom_right = br;
    frac_x             = fx;
    frac_y             = fy;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  task automatic write_mode(input awbs_pkg::mode_t m);
    sample_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    cur_mode  = m;
    sb.set_mode(m);
  endtask

  task automatic run_directed();
    logic [63:0] faint_tl;
    faint_tl = 64'd1 << (3 * chan_width());
    offer_sample('0, '0, '0, '0, 16'h0000, 16'h0000);
    offer_sample('1, '1, '1, '1, 16'hFFFF, 16'hFFFF);
    // four zero alphas
    offer_sample(make_pixel(PK_CLEAR), make_pixel(PK_CLEAR), make_pixel(PK_CLEAR),
                 make_pixel(PK_CLEAR), 16'h8000, 16'h8000);
    // nonzero alpha that rounds to zero
    offer_sample(faint_tl | 64'hFF, '0, '0, '0, 16'hFFFF, 16'hFFFF);
    offer_sample(make_pixel(PK_OPAQUE), make_pixel(PK_OPAQUE), make_pixel(PK_OPAQUE),
                 make_pixel(PK_OPAQUE), 16'h8000, 16'h8000);
    offer_sample(make_pixel(PK_OPAQUE), make_pixel(PK_RANDOM), make_pixel(PK_RANDOM),
                 make_pixel(PK_RANDOM), 16'h0000, 16'h0000);
    offer_sample(make_pixel(PK_OPAQUE), make_pixel(PK_OPAQUE), make_pixel(PK_OPAQUE),
                 make_pixel(PK_OPAQUE), 16'hFFFF, 16'h0000);
    offer_sample(make_pixel(PK_OPAQUE), make_pixel(PK_OPAQUE), make_pixel(PK_OPAQUE),
                 make_pixel(PK_OPAQUE), 16'h0000, 16'hFFFF);
    offer_sample('1, make_pixel(PK_CLEAR), make_pixel(PK_RANDOM), make_pixel(PK_RANDOM),
                 16'h8000, 16'h0000);
    // channels at the maximum and, in 16-bit mode, above it, colour clamp
    offer_sample(make_pixel(PK_EDGES) | ((64'd1 << chan_width()) - 1), make_pixel(PK_EDGES),
                 make_pixel(PK_EDGES), make_pixel(PK_EDGES), make_frac(), make_frac());
    offer_sample(make_pixel(PK_FAINT), make_pixel(PK_FAINT), make_pixel(PK_FAINT),
                 make_pixel(PK_FAINT), 16'h0001, 16'hFFFE);
    offer_sample(make_pixel(PK_RANDOM), make_pixel(PK_RANDOM), make_pixel(PK_RANDOM),
                 make_pixel(PK_RANDOM), 16'($urandom), 16'($urandom));
  endtask

  task automatic run_random(input int count);
    logic [63:0] px[4];
    int          n, i, pick;
    pixel_kind_t kind;
    for (n = 0; n < count; n++) begin
      pick = $urandom_range(0, 9);
      for (i = 0; i < awbs_pkg::NUM_PIX; i++) begin
        if (pick == 0) begin
          kind = PK_CLEAR;
        end else if (pick == 1) begin
          kind = PK_FAINT;
        end else if ($urandom_range(0, 1) == 0) begin
          kind = PK_RANDOM;
        end else begin
          kind = pixel_kind_t'($urandom_range(0, 6));
        end
        px[i] = make_pixel(kind);
      end
      offer_sample(px[0], px[1], px[2], px[3], make_frac(), make_frac());
    end
  endtask

  initial begin
    int p;
    sb                 = new();
    cur_mode           = awbs_pkg::MODE_8BIT;
    samples_taken      = 0;
    quiet_cycles       = 0;
    burst_left         = 0;
    hold_done          = 1'b0;
    rst                = 1'b1;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = 1'b0;
    sample_valid       = 1'b0;
    pixel_top_left     = '0;
    pixel_top_right    = '0;
    pixel_bottom_left  = '0;
    pixel_bottom_right = '0;
    frac_x             = '0;
    frac_y             = '0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    for (p = 0; p < NUM_PHASES; p++) begin
      write_mode((p % 2 == 0) ? awbs_pkg::MODE_8BIT : awbs_pkg::MODE_16BIT);
      if (p < 2) run_directed();
      run_random(PHASE_ITEMS);
    end

    sample_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
